// ===== rtl/infix_arithmetic_line_evaluator_unit_assert.svh =====
// Assertion macros for the infix line evaluator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef INFIX_ARITHMETIC_LINE_EVALUATOR_UNIT_ASSERT_SVH
`define INFIX_ARITHMETIC_LINE_EVALUATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define IALE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define IALE_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define IALE_ASSERT(name, prop, msg)
`define IALE_ASSERT_RST(name, prop, msg)
`endif
`endif

// ===== rtl/iale_pkg.sv =====
// Types and constants of the infix line evaluator.
// No dependencies; used by the top level, the checker and the testbench.
package iale_pkg;

  localparam int FRAC_BITS  = 32;
  localparam int VALUE_BITS = 64;
  localparam int NUM_BITS   = 31;
  localparam int ACC_BITS   = VALUE_BITS + NUM_BITS;
  localparam int MUL_STEPS  = NUM_BITS;
  localparam int DIV_STEPS  = VALUE_BITS;
  localparam int CNT_BITS   = 6;
  localparam int SUM_BITS   = VALUE_BITS + 2;

  localparam logic [NUM_BITS-1:0] NUM_LIMIT = {NUM_BITS{1'b1}};
  localparam logic [VALUE_BITS-1:0] MAX_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] MIN_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [3:0] RADIX    = 4'd10;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SYMBOL = 3'd1,
    ST_EXPR   = 3'd2,
    ST_DIV0   = 3'd3,
    ST_OVF    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_SYMBOL = 2'd1,
    ERR_EXPR   = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    K_START     = 2'd0,
    K_NUMBER    = 2'd1,
    K_OPERATOR  = 2'd2,
    K_NUM_SPACE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    T_NONE = 2'd0,
    T_MUL  = 2'd1,
    T_DIV  = 2'd2
  } term_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_PACK,
    S_FOLD,
    S_DONE
  } state_e;

endpackage

// ===== rtl/iale_in_if.sv =====
// Input channel of the infix line evaluator: one character or an end marker.
// Depends on nothing.
interface iale_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       line_end;

  modport source (output valid, output character, output line_end, input ready);
  modport sink (input valid, input character, input line_end, output ready);
endinterface

// ===== rtl/iale_out_if.sv =====
// Result channel of the infix line evaluator: status and Q32.32 value.
// Depends on nothing.
interface iale_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [63:0] value;

  modport source (output valid, output status, output value, input ready);
  modport sink (input valid, input status, input value, output ready);
endinterface

// ===== rtl/infix_arithmetic_line_evaluator_unit.sv =====
// Infix line evaluator top level: token tracking, bit-serial multiply and divide,
// saturating fold. Depends on iale_pkg, iale_in_if, iale_out_if and the assert header.
//
// One line of text enters one character per item and closes with an end-marker item;
// the block returns one status and one signed Q32.32 value per line. An operator or
// the end marker finishes the pending number: with no pending * or / it becomes the
// term, a pending * runs a bit-serial multiplier of 31 steps and then the pack state,
// a pending / by a nonzero number runs a restoring divider of 64 steps and then the
// pack state. After a number, +, - and the end marker pass the saturating fold, and
// the end marker then loads the result register. No new item is taken outside the
// idle state. The next line may start while a result waits.
`include "infix_arithmetic_line_evaluator_unit_assert.svh"

module infix_arithmetic_line_evaluator_unit
  import iale_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  iale_in_if.sink    in_i,
  iale_out_if.source out_o
);

  state_e                  state_q, state_d;
  logic [VALUE_BITS-1:0]   sum_q, sum_d, term_q, term_d;
  logic [NUM_BITS-1:0]     nb_q, nb_d;
  logic                    sign_q, sign_d, nsign_q, nsign_d;
  term_op_e                op_q, op_d;
  kind_e                   kind_q, kind_d;
  err_e                    err_q, err_d;
  logic                    dbz_q, dbz_d, ovf_q, ovf_d;
  logic                    fold_q, fold_d, end_q, end_d;
  logic                    neg_q, neg_d, xmul_q, xmul_d;
  logic [VALUE_BITS-1:0]   mag_q, mag_d;
  logic [NUM_BITS-1:0]     opnd_q, opnd_d, rem_q, rem_d;
  logic [ACC_BITS-1:0]     acc_q, acc_d;
  logic [CNT_BITS-1:0]     cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;
  status_e                 out_status_q, out_status_d;
  logic [VALUE_BITS-1:0]   out_value_q, out_value_d;

  logic                    accept_w, slot_free_w, kind_ok_w;
  logic                    is_digit_w, is_space_w, is_addop_w, is_op_w, start_w;
  logic [3:0]              digit_w;
  logic [NUM_BITS+3:0]     grow_w;
  logic [NUM_BITS:0]       div_t_w;
  logic [VALUE_BITS-1:0]   pack_res_w, pack_lim_w;
  logic                    pack_big_w;
  logic [SUM_BITS-1:0]     sa_w, sb_w, ss_w;
  status_e                 stat_w;
  state_e                  after_w;

  function automatic err_e merge_err(err_e cur, err_e code);
    merge_err = (cur == ERR_NONE || code < cur) ? code : cur;
  endfunction

  assign in_i.ready   = (state_q == S_IDLE);
  assign accept_w     = in_i.valid & in_i.ready;
  assign slot_free_w  = !out_valid_q || out_o.ready;
  assign kind_ok_w    = (kind_q == K_NUMBER) || (kind_q == K_NUM_SPACE);
  assign is_digit_w   = (in_i.character >= CH_ZERO) && (in_i.character <= CH_NINE);
  assign is_space_w   = (in_i.character == CH_SPACE);
  assign is_addop_w   = (in_i.character == CH_PLUS) || (in_i.character == CH_MINUS);
  assign is_op_w      = is_addop_w || (in_i.character == CH_STAR) ||
                        (in_i.character == CH_SLASH);
  assign digit_w      = in_i.character[3:0];
  // the pending number is finished by an operator or end marker after a number
  assign start_w      = accept_w && kind_ok_w && (in_i.line_end || is_op_w);
  assign grow_w       = ({4'b0, nb_q} << 3) + ({4'b0, nb_q} << 1) + (NUM_BITS+4)'(digit_w);
  assign div_t_w      = {rem_q, mag_q[VALUE_BITS-1]};
  assign after_w      = (in_i.line_end || is_addop_w) ? S_FOLD : S_IDLE;

  // multiply result is acc bits [63:0]; the product is already Q32.32
  assign pack_res_w   = xmul_q ? acc_q[VALUE_BITS-1:0] : mag_q;
  assign pack_big_w   = xmul_q ? (|acc_q[ACC_BITS-1:VALUE_BITS]) : 1'b0;
  assign pack_lim_w   = neg_q ? MIN_NEG : MAX_POS;

  assign sa_w = {{2{sum_q[VALUE_BITS-1]}}, sum_q};
  assign sb_w = {{2{term_q[VALUE_BITS-1]}}, term_q};
  assign ss_w = sign_q ? (sa_w - sb_w) : (sa_w + sb_w);

  always_comb begin
    case (err_q)
      ERR_SYMBOL: stat_w = ST_SYMBOL;
      ERR_EXPR:   stat_w = ST_EXPR;
      default: begin
        if (dbz_q) stat_w = ST_DIV0;
        else if (ovf_q) stat_w = ST_OVF;
        else stat_w = ST_OK;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept_w && in_i.line_end && !kind_ok_w) begin
          state_d = S_DONE;
        end else if (start_w) begin
          case (op_q)
            T_MUL:   state_d = S_MUL;
            T_DIV:   state_d = (nb_q == '0) ? after_w : S_DIV;
            default: state_d = after_w;
          endcase
        end
      end
      S_MUL:  if (cnt_q == CNT_BITS'(MUL_STEPS - 1)) state_d = S_PACK;
      S_DIV:  if (cnt_q == CNT_BITS'(DIV_STEPS - 1)) state_d = S_PACK;
      S_PACK: state_d = (fold_q || end_q) ? S_FOLD : S_IDLE;
      S_FOLD: state_d = end_q ? S_DONE : S_IDLE;
      S_DONE: if (slot_free_w) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    sum_d = sum_q; term_d = term_q; nb_d = nb_q; sign_d = sign_q; nsign_d = nsign_q;
    op_d = op_q; kind_d = kind_q; err_d = err_q; dbz_d = dbz_q; ovf_d = ovf_q;
    fold_d = fold_q; end_d = end_q; neg_d = neg_q; xmul_d = xmul_q; mag_d = mag_q;
    opnd_d = opnd_q; rem_d = rem_q; acc_d = acc_q; cnt_d = cnt_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_status_d = out_status_q; out_value_d = out_value_q;

    case (state_q)
      S_IDLE: begin
        if (accept_w) begin
          if (in_i.line_end) begin
            fold_d = 1'b1;
            end_d  = 1'b1;
            if (!kind_ok_w) err_d = merge_err(err_q, ERR_EXPR);
          end else if (is_digit_w) begin
            if (kind_q == K_NUM_SPACE) err_d = merge_err(err_q, ERR_EXPR);
            if (kind_q == K_NUMBER) begin
              if (grow_w > (NUM_BITS+4)'(NUM_LIMIT)) begin
                nb_d  = NUM_LIMIT;
                ovf_d = 1'b1;
              end else begin
                nb_d = grow_w[NUM_BITS-1:0];
              end
            end else begin
              nb_d = NUM_BITS'(digit_w);
            end
            kind_d = K_NUMBER;
          end else if (is_space_w) begin
            if (kind_q == K_NUMBER) kind_d = K_NUM_SPACE;
          end else if (is_op_w) begin
            if (!kind_ok_w) begin
              err_d = merge_err(err_q, ERR_EXPR);
            end else begin
              fold_d = is_addop_w;
              end_d  = 1'b0;
              if (is_addop_w) begin
                nsign_d = (in_i.character == CH_MINUS);
                op_d    = T_NONE;
              end else begin
                op_d = (in_i.character == CH_STAR) ? T_MUL : T_DIV;
              end
            end
            kind_d = K_OPERATOR;
          end else begin
            err_d = merge_err(err_q, ERR_SYMBOL);
          end
          if (start_w) begin
            // load the serial unit; op_q still holds the operator before the number
            neg_d  = term_q[VALUE_BITS-1];
            mag_d  = term_q[VALUE_BITS-1] ? (VALUE_BITS'(0) - term_q) : term_q;
            opnd_d = nb_q;
            acc_d  = '0;
            rem_d  = '0;
            cnt_d  = '0;
            xmul_d = (op_q == T_MUL);
            nb_d   = '0;
            case (op_q)
              T_MUL: ;
              T_DIV: if (nb_q == '0) dbz_d = 1'b1;
              default: term_d = {1'b0, nb_q, {FRAC_BITS{1'b0}}};
            endcase
          end
        end
      end
      S_MUL: begin
        acc_d  = {acc_q[ACC_BITS-2:0], 1'b0} +
                 (opnd_q[NUM_BITS-1] ? ACC_BITS'(mag_q) : ACC_BITS'(0));
        opnd_d = {opnd_q[NUM_BITS-2:0], 1'b0};
        cnt_d  = cnt_q + 1'b1;
      end
      S_DIV: begin
        if (div_t_w >= {1'b0, opnd_q}) begin
          rem_d = NUM_BITS'(div_t_w - {1'b0, opnd_q});
          mag_d = {mag_q[VALUE_BITS-2:0], 1'b1};
        end else begin
          rem_d = div_t_w[NUM_BITS-1:0];
          mag_d = {mag_q[VALUE_BITS-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
      end
      S_PACK: begin
        if (pack_big_w || pack_res_w > pack_lim_w) begin
          ovf_d  = 1'b1;
          term_d = neg_q ? (VALUE_BITS'(0) - pack_lim_w) : pack_lim_w;
        end else begin
          term_d = neg_q ? (VALUE_BITS'(0) - pack_res_w) : pack_res_w;
        end
      end
      S_FOLD: begin
        if (ss_w[SUM_BITS-1:VALUE_BITS-1] == '0 || ss_w[SUM_BITS-1:VALUE_BITS-1] == '1) begin
          sum_d = ss_w[VALUE_BITS-1:0];
        end else begin
          ovf_d = 1'b1;
          sum_d = ss_w[SUM_BITS-1] ? MIN_NEG : MAX_POS;
        end
        term_d = '0;
        sign_d = nsign_q;
      end
      S_DONE: begin
        if (slot_free_w) begin
          out_valid_d  = 1'b1;
          out_status_d = stat_w;
          out_value_d  = (stat_w == ST_OK || stat_w == ST_OVF) ? sum_q : '0;
          // back to line start
          sum_d = '0; term_d = '0; nb_d = '0; sign_d = 1'b0; nsign_d = 1'b0;
          op_d = T_NONE; kind_d = K_START; err_d = ERR_NONE;
          dbz_d = 1'b0; ovf_d = 1'b0; fold_d = 1'b0; end_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      term_q      <= '0;
      nb_q        <= '0;
      sign_q      <= 1'b0;
      nsign_q     <= 1'b0;
      op_q        <= T_NONE;
      kind_q      <= K_START;
      err_q       <= ERR_NONE;
      dbz_q       <= 1'b0;
      ovf_q       <= 1'b0;
      fold_q      <= 1'b0;
      end_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      term_q      <= term_d;
      nb_q        <= nb_d;
      sign_q      <= sign_d;
      nsign_q     <= nsign_d;
      op_q        <= op_d;
      kind_q      <= kind_d;
      err_q       <= err_d;
      dbz_q       <= dbz_d;
      ovf_q       <= ovf_d;
      fold_q      <= fold_d;
      end_q       <= end_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q        <= neg_d;
    xmul_q       <= xmul_d;
    mag_q        <= mag_d;
    opnd_q       <= opnd_d;
    rem_q        <= rem_d;
    acc_q        <= acc_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.value  = out_value_q;

  `IALE_ASSERT_RST(a_no_result_in_reset, !rst_ni |-> !out_o.valid, "result valid during reset")
  `IALE_ASSERT(a_value_only_ok, (out_o.valid && out_o.value != '0) |-> (out_o.status == ST_OK || out_o.status == ST_OVF), "value set with error status")
  `IALE_ASSERT(a_done_loads, (state_q == S_DONE && slot_free_w) |=> (state_q == S_IDLE && out_o.valid && kind_q == K_START), "end of line did not load result")
  `IALE_ASSERT(a_mul_starts_clear, (state_q != S_MUL ##1 state_q == S_MUL) |-> cnt_q == '0, "multiply entered with stale step count")
endmodule

// ===== tb/sv/iale_line_audit.sv =====
// Checker of the infix line evaluator: watches both channels, predicts each line's result.
// Depends on iale_pkg, iale_in_if and iale_out_if.
module iale_line_audit
  import iale_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  iale_in_if   in_i,
  iale_out_if  out_i,
  output int   errors_o,
  output int   pending_o,
  output int   lines_o,
  output int   ovf_lines_o
);

  typedef struct packed {
    status_e         st;
    logic [63:0]     val;
  } line_result_t;

  line_result_t    line_results_q[$];

  logic [63:0] sum_acc;
  logic [63:0] term_acc;
  logic [31:0] num_acc;
  logic        minus_pending;
  term_op_e    term_op;
  kind_e       last_kind;
  err_e        first_err;
  logic        div0_seen;
  logic        ovf_seen;

  assign pending_o = line_results_q.size();

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // Saturate a sign and magnitude into the signed value range.
  function automatic logic [63:0] sat_pack(logic neg, logic big, logic [63:0] m);
    logic [63:0] lim;
    lim = MAX_POS + {63'd0, neg};
    if (big || m > lim) begin
      ovf_seen = 1'b1;
      m = lim;
    end
    return neg ? -m : m;
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b, logic negb);
    logic        na;
    logic        nb;
    logic [64:0] s;
    na = a[63];
    nb = b[63] ^ negb;
    if (na == nb) begin
      s = {1'b0, mag(a)} + {1'b0, mag(b)};
      return sat_pack(na, s[64], s[63:0]);
    end
    if (mag(a) >= mag(b)) return sat_pack(na, 1'b0, mag(a) - mag(b));
    return sat_pack(nb, 1'b0, mag(b) - mag(a));
  endfunction

  function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, mag(a)} * {64'd0, mag(b)};
    return sat_pack(a[63] ^ b[63], p[127:96] != 0, p[95:32]);
  endfunction

  function automatic logic [63:0] div_sat(logic [63:0] a, logic [63:0] b);
    logic [127:0] q;
    q = {32'd0, mag(a), 32'd0} / {64'd0, mag(b)};
    return sat_pack(a[63] ^ b[63], q[127:64] != 0, q[63:0]);
  endfunction

  function automatic void note_err(err_e code);
    if (first_err == ERR_NONE || code < first_err) first_err = code;
  endfunction

  function automatic void finish_number();
    logic [63:0] v;
    v = {num_acc, 32'd0};
    if (term_op == T_MUL) term_acc = mul_sat(term_acc, v);
    else if (term_op == T_DIV) begin
      if (v == 0) div0_seen = 1'b1;
      else term_acc = div_sat(term_acc, v);
    end else term_acc = v;
    num_acc = '0;
  endfunction

  function automatic void fold_term();
    sum_acc = add_sat(sum_acc, term_acc, minus_pending);
    term_acc = '0;
  endfunction

  function automatic void clear_line();
    sum_acc = '0;
    term_acc = '0;
    num_acc = '0;
    minus_pending = 1'b0;
    term_op = T_NONE;
    last_kind = K_START;
    first_err = ERR_NONE;
    div0_seen = 1'b0;
    ovf_seen = 1'b0;
  endfunction

  function automatic void take_char(logic [7:0] c, logic eol);
    line_result_t r;
    logic [63:0]  t;
    if (eol) begin
      if (last_kind == K_START || last_kind == K_OPERATOR) note_err(ERR_EXPR);
      else begin
        finish_number();
        fold_term();
      end
      r.val = '0;
      if (first_err == ERR_SYMBOL) r.st = ST_SYMBOL;
      else if (first_err == ERR_EXPR) r.st = ST_EXPR;
      else if (div0_seen) r.st = ST_DIV0;
      else r.st = ovf_seen ? ST_OVF : ST_OK;
      if (r.st == ST_OK || r.st == ST_OVF) r.val = sum_acc;
      if (r.st == ST_OVF) ovf_lines_o++;
      line_results_q.insert(line_results_q.size(), r);
      clear_line();
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      if (last_kind == K_NUM_SPACE) note_err(ERR_EXPR);
      t = {60'd0, c[3:0]};
      if (last_kind == K_NUMBER) t = {32'd0, num_acc} * 10 + t;
      if (t > {33'd0, NUM_LIMIT}) begin
        t = {33'd0, NUM_LIMIT};
        ovf_seen = 1'b1;
      end
      num_acc = t[31:0];
      last_kind = K_NUMBER;
    end else if (c == CH_SPACE) begin
      if (last_kind == K_NUMBER) last_kind = K_NUM_SPACE;
    end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
      if (last_kind == K_START || last_kind == K_OPERATOR) note_err(ERR_EXPR);
      else begin
        finish_number();
        if (c == CH_PLUS || c == CH_MINUS) begin
          fold_term();
          minus_pending = (c == CH_MINUS);
          term_op = T_NONE;
        end else term_op = (c == CH_STAR) ? T_MUL : T_DIV;
      end
      last_kind = K_OPERATOR;
    end else note_err(ERR_SYMBOL);
  endfunction

  initial begin
    errors_o = 0;
    lines_o = 0;
    ovf_lines_o = 0;
    clear_line();
  end

  always @(posedge clk_i) begin
    line_result_t r;
    if (rst_ni) begin
      if (in_i.valid && in_i.ready) take_char(in_i.character, in_i.line_end);
      if (out_i.valid && out_i.ready) begin
        lines_o++;
        if (line_results_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result status %0d value %h",
                   $time, out_i.status, out_i.value);
        end else begin
          r = line_results_q.pop_front();
          if (out_i.status !== r.st) begin
            errors_o++;
            $display("%0t: status expected %0d actual %0d", $time, r.st, out_i.status);
          end
          if (out_i.value !== r.val) begin
            errors_o++;
            $display("%0t: value expected %h actual %h", $time, r.val, out_i.value);
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/infix_arithmetic_line_evaluator_unit_test.sv =====
// Testbench top of the infix line evaluator: clock, reset, line stimulus, verdict.
// Depends on iale_pkg, the interfaces, the evaluator and iale_line_audit.
module infix_arithmetic_line_evaluator_unit_test;
  import iale_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic quiet = 1'b0;
  int   errors;
  int   pending;
  int   lines;
  int   ovf_lines;
  int   sent;
  int   stall_left = 0;

  iale_in_if  in_ch ();
  iale_out_if out_ch ();

  infix_arithmetic_line_evaluator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  iale_line_audit audit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_i       (out_ch),
    .errors_o    (errors),
    .pending_o   (pending),
    .lines_o     (lines),
    .ovf_lines_o (ovf_lines)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.character = '0;
    in_ch.line_end = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Hold ready low for random bursts, none in the quiet tail.
  always @(posedge clk_i) begin
    if (quiet) out_ch.ready <= 1'b1;
    else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else out_ch.ready <= 1'b1;
  end

  task automatic push(logic [7:0] c, logic eol);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.character <= c;
    in_ch.line_end <= eol;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
  endtask

  task automatic send_line(string s);
    foreach (s[i]) push(s[i], 1'b0);
    push(8'($urandom), 1'b1);
  endtask

  function automatic string rand_number();
    string s;
    int    n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
    s = "";
    repeat (n) s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string rand_spaces();
    return ($urandom_range(0, 3) == 0) ? " " : "";
  endfunction

  function automatic string rand_line();
    string s;
    byte   ops[4];
    int    k;
    ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    s = "";
    k = $urandom_range(0, 9);
    if (k < 8) begin
      // well-formed expression with random content
      s = {rand_spaces(), rand_number()};
      repeat ($urandom_range(0, 5))
        s = {s, rand_spaces(), string'(ops[$urandom_range(0, 3)]), rand_spaces(),
             rand_number()};
      s = {s, rand_spaces()};
      if ($urandom_range(0, 7) == 0) s = {s, "/0"};
    end else begin
      // broken sequences and arbitrary bytes
      repeat ($urandom_range(0, 8)) begin
        if ($urandom_range(0, 2) == 0) s = {s, string'(8'($urandom))};
        else s = {s, string'(ops[$urandom_range(0, 3)]), rand_number(), rand_spaces()};
      end
    end
    return s;
  endfunction

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  initial begin
    string directed[$];
    sent = 0;
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed = '{"0", "2147483647", "99999999999", "1+2*3-4/2", "7/0", "12 34",
                 "+1", "1++2", "1+", "", "   ", "1a+2", "x+/0", "1/0*99999999999",
                 "2147483647*2147483647*4", "0-2147483647*2147483647*2", "1/3",
                 "5-9", "0-1/3*3", " 6 / 4 - 0 * 9 "};
    foreach (directed[i]) send_line(directed[i]);
    send_line({8'h00, 8'hFF});
    // hold off until the block has returned everything
    in_ch.valid <= 1'b0;
    drain();
    while (sent < 1550) begin
      if (sent > 1350) quiet = 1'b1;
      send_line(rand_line());
    end
    in_ch.valid <= 1'b0;
    drain();
    $display("Checked %0d lines from %0d items, %0d of them saturated.",
             lines, sent, ovf_lines);
    if (errors == 0 && pending == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout with %0d results outstanding", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== infix_arithmetic_line_evaluator_unit.f =====
+incdir+rtl
rtl/iale_pkg.sv
rtl/iale_in_if.sv
rtl/iale_out_if.sv
rtl/infix_arithmetic_line_evaluator_unit.sv
tb/sv/iale_line_audit.sv
tb/sv/infix_arithmetic_line_evaluator_unit_test.sv
